>>> rtl/ntn_pkg.sv
// Package: shared constants, payload types and the letter case function.
`timescale 1ns / 1ps

package ntn_pkg;

    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_DOT      = 8'd46;
    localparam logic [7:0] UPPER_A     = 8'd65;
    localparam logic [7:0] UPPER_Z     = 8'd90;
    localparam logic [7:0] LOWER_A     = 8'd97;
    localparam logic [7:0] LOWER_Z     = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam int MAX_RES   = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_end;
    } t_out_item;

    // All results caused by one input byte, in order from index 0.
    typedef struct packed {
        t_out_item [MAX_RES-1:0] res;
        logic [RES_CNT_W-1:0]    cnt;
    } t_bundle;

    function automatic logic [7:0] shape_letter(input logic [7:0] b, input logic upper);
        logic [7:0] r;
        r = b;
        if (r inside {[UPPER_A:UPPER_Z]}) begin
            r = r + CASE_OFFSET;
        end
        if (upper && (r inside {[LOWER_A:LOWER_Z]})) begin
            r = r - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

>>> rtl/ntn_stream_if.sv
// Interface: valid/ready channel with a typed payload.
`timescale 1ns / 1ps

interface ntn_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ntn_front.sv
// Front end: classifies each byte, tracks held space/period, emits result bundles.
`timescale 1ns / 1ps

module ntn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ntn_stream_if.sink    i_in,
    ntn_stream_if.source  o_bnd
);

    logic r_started, r_sp, r_dot, r_sad;
    logic n_started, n_sp, n_dot, n_sad;
    ntn_pkg::t_bundle bnd;
    logic accept;

    always_comb begin
        logic [7:0]                    b;
        logic                          prev;
        logic [ntn_pkg::RES_CNT_W-1:0] cnt;
        logic [ntn_pkg::RES_CNT_W-1:0] tail;
        b         = i_in.data.in_byte;
        prev      = 1'b0;
        cnt       = '0;
        tail      = '0;
        bnd       = '0;
        n_started = r_started;
        n_sp      = r_sp;
        n_dot     = r_dot;
        n_sad     = r_sad;

        if (b == ntn_pkg::CH_SPACE) begin
            if (n_started) begin
                if (n_dot) begin
                    n_sad = 1'b1;
                end else begin
                    n_sp = 1'b1;
                end
            end
        end else begin
            if (n_dot) begin
                bnd.res[cnt[ntn_pkg::RES_IDX_W-1:0]] = {ntn_pkg::CH_SPACE, 1'b1, 1'b0};
                cnt = cnt + 1'b1;
                bnd.res[cnt[ntn_pkg::RES_IDX_W-1:0]] = {ntn_pkg::CH_DOT, 1'b1, 1'b0};
                cnt   = cnt + 1'b1;
                n_dot = 1'b0;
                n_sp  = n_sad;
                n_sad = 1'b0;
            end
            if (b == ntn_pkg::CH_DOT && n_sp && n_started) begin
                n_dot = 1'b1;
            end else begin
                if (n_sp) begin
                    bnd.res[cnt[ntn_pkg::RES_IDX_W-1:0]] = {ntn_pkg::CH_SPACE, 1'b1, 1'b0};
                    cnt  = cnt + 1'b1;
                    prev = 1'b1;
                    n_sp = 1'b0;
                end
                bnd.res[cnt[ntn_pkg::RES_IDX_W-1:0]] =
                    {ntn_pkg::shape_letter(b, !n_started || prev), 1'b1, 1'b0};
                cnt       = cnt + 1'b1;
                n_started = 1'b1;
            end
        end

        if (i_in.data.in_last) begin
            if (n_dot) begin
                bnd.res[cnt[ntn_pkg::RES_IDX_W-1:0]] = {ntn_pkg::CH_DOT, 1'b1, 1'b0};
                cnt = cnt + 1'b1;
            end
            if (cnt == '0) begin
                bnd.res[0] = '0;
                cnt        = cnt + 1'b1;
            end
            tail = cnt - 1'b1;
            bnd.res[tail[ntn_pkg::RES_IDX_W-1:0]].out_end = 1'b1;
            n_started = 1'b0;
            n_sp      = 1'b0;
            n_dot     = 1'b0;
            n_sad     = 1'b0;
        end
        bnd.cnt = cnt;
    end

    assign i_in.ready  = o_bnd.ready;
    assign o_bnd.valid = i_in.valid && (bnd.cnt != '0);
    assign o_bnd.data  = bnd;
    assign accept      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_sp      <= 1'b0;
            r_dot     <= 1'b0;
            r_sad     <= 1'b0;
        end else if (accept) begin
            r_started <= n_started;
            r_sp      <= n_sp;
            r_dot     <= n_dot;
            r_sad     <= n_sad;
        end
    end

endmodule

>>> rtl/ntn_queue.sv
// Bundle queue: small FIFO between the front end and the output sequencer.
`timescale 1ns / 1ps

module ntn_queue #(
    parameter int DEPTH = ntn_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ntn_stream_if.sink    i_push,
    ntn_stream_if.source  o_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ntn_pkg::t_bundle r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push, pop;

    assign i_push.ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop.valid  = (r_cnt != '0);
    assign o_pop.data   = r_mem[r_rd];
    assign push         = i_push.valid && i_push.ready;
    assign pop          = o_pop.valid && o_pop.ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/ntn_back.sv
// Back end: walks each bundle one result per cycle, while the output is not stalled, into the output register.
`timescale 1ns / 1ps

module ntn_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ntn_stream_if.sink    i_bnd,
    ntn_stream_if.source  o_out
);

    logic [ntn_pkg::RES_IDX_W-1:0] r_idx;
    ntn_pkg::t_out_item            r_out;
    logic                          r_vld;
    logic                          load, last_sub;

    assign load     = i_bnd.valid && (!r_vld || o_out.ready);
    assign last_sub = (ntn_pkg::RES_CNT_W'(r_idx) == (i_bnd.data.cnt - 1'b1));

    assign i_bnd.ready = load && last_sub;
    assign o_out.valid = r_vld;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= i_bnd.data.res[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_vld <= 1'b0;
        end else begin
            if (load) begin
                r_vld <= 1'b1;
                r_idx <= last_sub ? '0 : r_idx + 1'b1;
            end else if (o_out.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/name_text_normalizer_unit.sv
// Top level: space collapse and title-case normalizer for a byte stream.
//
//  channel   dir  payload                          transfer
//  i_in      in   in_byte[7:0], in_last            valid & ready
//  o_out     out  out_byte[7:0], out_valid, out_end valid & ready
//
// One input byte per cycle; each byte yields zero to four results, which
// leave one per cycle, while o_out is ready, from a registered output stage.
// A queue of QUEUE_DEPTH result bundles separates input from output, so the
// input stalls only when that queue is full.
// Reset (synchronous, active low) clears the held space/period state, empties the
// queue and clears the output valid flag and result index.
`timescale 1ns / 1ps

module name_text_normalizer_unit #(
    parameter int QUEUE_DEPTH = ntn_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ntn_stream_if.sink    i_in,
    ntn_stream_if.source  o_out
);

    ntn_stream_if #(.T(ntn_pkg::t_bundle)) u_push ();
    ntn_stream_if #(.T(ntn_pkg::t_bundle)) u_pop ();

    ntn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_bnd   (u_push.source)
    );

    ntn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (u_push.sink),
        .o_pop   (u_pop.source)
    );

    ntn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bnd   (u_pop.sink),
        .o_out   (o_out)
    );

endmodule
